// ===== hw/rtl/crc8pc_pkg.sv =====
// ----------------------------------------------------------------------------
// crc8pc_pkg
// Shared types, codes and the CRC-8 byte update for the packet checker.
// ----------------------------------------------------------------------------
package crc8pc_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned EVENT_W = 3;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [BYTE_W-1:0] CRC_POLY  = 8'h07;
  localparam logic [BYTE_W-1:0] COUNT_MAX = 8'hFF;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_START   = 8'd1;

  localparam logic [BYTE_W-1:0] OWN_ADDRESS_RST = 8'h00;
  localparam logic [BYTE_W-1:0] CRC_START_RST   = 8'hFF;

  // Packet type byte values.
  localparam logic [BYTE_W-1:0] TYPE_G1_OPEN     = 8'h01;
  localparam logic [BYTE_W-1:0] TYPE_G1_CLOSED   = 8'h02;
  localparam logic [BYTE_W-1:0] TYPE_FD_OPEN     = 8'h04;
  localparam logic [BYTE_W-1:0] TYPE_FD_CLOSED   = 8'h05;
  localparam logic [BYTE_W-1:0] TYPE_MBOX_CHANGE = 8'h06;
  localparam logic [BYTE_W-1:0] TYPE_PING        = 8'hFF;

  // Event codes.
  localparam logic [EVENT_W-1:0] EV_NONE      = 3'd0;
  localparam logic [EVENT_W-1:0] EV_G1_OPEN   = 3'd1;
  localparam logic [EVENT_W-1:0] EV_G1_CLOSED = 3'd2;
  localparam logic [EVENT_W-1:0] EV_FD_OPEN   = 3'd3;
  localparam logic [EVENT_W-1:0] EV_FD_CLOSED = 3'd4;
  localparam logic [EVENT_W-1:0] EV_MBOX      = 3'd5;
  localparam logic [EVENT_W-1:0] EV_PING      = 3'd6;
  localparam logic [EVENT_W-1:0] EV_UNKNOWN   = 3'd7;

  typedef struct packed {
    logic               crc_ok;
    logic               for_us;
    logic [EVENT_W-1:0] event_code;
    logic [BYTE_W-1:0]  packet_length;
  } result_t;

  typedef struct packed {
    logic [BYTE_W-1:0] own_address;
    logic [BYTE_W-1:0] crc_start;
  } cfg_t;

  // Non-reflected CRC-8 update of one byte, MSB first.
  function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] m);
    logic [BYTE_W-1:0] v;
    v = crc ^ m;
    for (int k = 0; k < BYTE_W; k++) begin
      if (v[BYTE_W-1]) begin
        v = {v[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[BYTE_W-2:0], 1'b0};
      end
    end
    return v;
  endfunction

  function automatic logic [EVENT_W-1:0] classify(input logic [BYTE_W-1:0] t);
    logic [EVENT_W-1:0] ev;
    unique case (t)
      TYPE_G1_OPEN:     ev = EV_G1_OPEN;
      TYPE_G1_CLOSED:   ev = EV_G1_CLOSED;
      TYPE_FD_OPEN:     ev = EV_FD_OPEN;
      TYPE_FD_CLOSED:   ev = EV_FD_CLOSED;
      TYPE_MBOX_CHANGE: ev = EV_MBOX;
      TYPE_PING:        ev = EV_PING;
      default:          ev = EV_UNKNOWN;
    endcase
    return ev;
  endfunction

endpackage

// ===== hw/rtl/crc8pc_if.sv =====
// ----------------------------------------------------------------------------
// crc8pc_if
// Valid/ready channels for packet bytes, check results and register writes.
// ----------------------------------------------------------------------------
interface crc8pc_in_if import crc8pc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface crc8pc_out_if import crc8pc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               crc_ok;
  logic               for_us;
  logic [EVENT_W-1:0] event_code;
  logic [BYTE_W-1:0]  packet_length;

  modport source (output valid, output crc_ok, output for_us, output event_code,
                  output packet_length, input ready);
  modport sink   (input valid, input crc_ok, input for_us, input event_code,
                  input packet_length, output ready);
endinterface

interface crc8pc_cfg_if import crc8pc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BYTE_W-1:0]    wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== hw/rtl/crc8_packet_check_classifier.sv =====
// ----------------------------------------------------------------------------
// crc8_packet_check_classifier
// Checks the CRC-8 of received radio packets and classifies their event type.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload                                     Per item
//   in_chan   sink       data_byte[7:0], last_byte                   one byte
//   out_chan  source     crc_ok, for_us, event_code[2:0],            one packet
//                        packet_length[7:0]
//   cfg_chan  sink       index[7:0], wdata[7:0]                      one write
//
// The block takes one byte per clock cycle while in_chan.ready is high. The
// CRC-8 update of a byte is a single shallow XOR network, so the packet state
// registers close each cycle. Each result is registered in the output buffer.
// Reset (rst_n low, synchronous) clears the packet state, empties the output
// buffer and loads the register defaults (own address 0, CRC start 0xFF).
// A stalled output holds up to two results; in_chan drops ready only while
// both slots are full, and non-final bytes are otherwise taken freely.
//
module crc8_packet_check_classifier import crc8pc_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  crc8pc_in_if.sink      in_chan,
  crc8pc_out_if.source   out_chan,
  crc8pc_cfg_if.sink     cfg_chan
);

  cfg_t    cfg_r;
  logic    in_accept;
  logic    res_push;
  logic    can_push;
  result_t res_data;
  result_t out_data;

  // Configuration writes are always taken; unknown indexes are ignored.
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_address <= OWN_ADDRESS_RST;
      cfg_r.crc_start   <= CRC_START_RST;
    end else if (cfg_chan.valid) begin
      if (cfg_chan.index == CFG_OWN_ADDRESS) begin
        cfg_r.own_address <= cfg_chan.wdata;
      end
      if (cfg_chan.index == CFG_CRC_START) begin
        cfg_r.crc_start <= cfg_chan.wdata;
      end
    end
  end

  // Input bytes are accepted whenever the output buffer has a free slot.
  assign in_chan.ready = can_push;
  assign in_accept     = in_chan.valid && can_push;

  crc8pc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .data_byte (in_chan.data_byte),
    .last_byte (in_chan.last_byte),
    .cfg       (cfg_r),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  crc8pc_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_data),
    .can_push  (can_push),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_data  (out_data)
  );

  assign out_chan.crc_ok        = out_data.crc_ok;
  assign out_chan.for_us        = out_data.for_us;
  assign out_chan.event_code    = out_data.event_code;
  assign out_chan.packet_length = out_data.packet_length;

endmodule

// ===== hw/rtl/crc8pc_core.sv =====
// ----------------------------------------------------------------------------
// crc8pc_core
// Per-packet state: running CRC, byte count, destination and type bytes.
// ----------------------------------------------------------------------------
module crc8pc_core import crc8pc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              last_byte,
  input  cfg_t              cfg,
  output logic              res_push,
  output result_t           res_data
);

  logic [BYTE_W-1:0] running_crc_r, running_crc_nxt;
  logic [BYTE_W-1:0] byte_count_r, byte_count_nxt;
  logic [BYTE_W-1:0] dest_byte_r, dest_byte_nxt;
  logic [BYTE_W-1:0] type_byte_r, type_byte_nxt;

  logic              first;
  logic [BYTE_W-1:0] crc_cur, dest_cur, type_cur;
  logic              ok, us;

  assign first    = (byte_count_r == '0);
  assign crc_cur  = first ? cfg.crc_start : running_crc_r;
  assign dest_cur = first ? data_byte : dest_byte_r;
  assign type_cur = (byte_count_r == BYTE_W'(2)) ? data_byte : type_byte_r;
  assign ok       = (crc_cur == data_byte);
  assign us       = (dest_cur == cfg.own_address);

  assign res_push               = accept && last_byte;
  assign res_data.crc_ok        = ok;
  assign res_data.for_us        = us;
  assign res_data.event_code    = (ok && us) ? classify(type_cur) : EV_NONE;
  // The count holds bytes before the last one; adding the last saturates.
  assign res_data.packet_length = (byte_count_r == COUNT_MAX) ? COUNT_MAX
                                                              : byte_count_r + 1'b1;

  always_comb begin
    running_crc_nxt = running_crc_r;
    byte_count_nxt  = byte_count_r;
    dest_byte_nxt   = dest_byte_r;
    type_byte_nxt   = type_byte_r;
    if (accept) begin
      if (last_byte) begin
        running_crc_nxt = cfg.crc_start;
        byte_count_nxt  = '0;
        dest_byte_nxt   = '0;
        type_byte_nxt   = '0;
      end else begin
        running_crc_nxt = crc8_byte(crc_cur, data_byte);
        dest_byte_nxt   = dest_cur;
        type_byte_nxt   = type_cur;
        if (byte_count_r != COUNT_MAX) begin
          byte_count_nxt = byte_count_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_crc_r <= CRC_START_RST;
      byte_count_r  <= '0;
      dest_byte_r   <= '0;
      type_byte_r   <= '0;
    end else begin
      running_crc_r <= running_crc_nxt;
      byte_count_r  <= byte_count_nxt;
      dest_byte_r   <= dest_byte_nxt;
      type_byte_r   <= type_byte_nxt;
    end
  end

endmodule

// ===== hw/rtl/crc8pc_out_buf.sv =====
// ----------------------------------------------------------------------------
// crc8pc_out_buf
// Two-entry output register with skid slot; ready upstream is registered.
// ----------------------------------------------------------------------------
module crc8pc_out_buf import crc8pc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    can_push,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    main_valid_r, main_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t main_r, main_nxt;
  result_t skid_r, skid_nxt;
  logic    pop;

  assign pop       = main_valid_r && out_ready;
  assign can_push  = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  // A push never arrives while the skid slot is full.
  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (pop) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        main_valid_nxt = push;
        main_nxt       = push_data;
      end
    end else if (push) begin
      if (!main_valid_r) begin
        main_valid_nxt = 1'b1;
        main_nxt       = push_data;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_nxt       = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule
